>>> hw/rtl/htpm_pkg.sv
// Shared types and constants of the hysteresis trigger period meter.
`timescale 1ns / 1ps

package htpm_pkg;

   // Fixed field widths of the channels and the register port
   localparam int SAMPLE_W  = 12;
   localparam int LEVEL_W   = 12;
   localparam int TOTAL_W   = 4;
   localparam int INDEX_W   = 12;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_LEVEL = 2'd2;

   // Register reset values
   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = 12'd4095;
   localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST  = 12'd0;
   localparam logic [LEVEL_W-1:0] MEAN_LEVEL_RST = 12'd2048;

   // Controller to datapath
   typedef struct packed {
      logic accept;       // sample beat taken
      logic capture_end;  // taken beat carries last
      logic div_step;     // advance the divider one bit
      logic load_out;     // load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_last;     // divider is on its final bit
   } status_type;

endpackage

>>> hw/rtl/htpm_if.sv
// Sample and result channel interfaces of the hysteresis trigger period meter.
`timescale 1ns / 1ps

interface htpm_req_if;
   logic                          valid;
   logic                          ready;
   logic [htpm_pkg::SAMPLE_W-1:0] sample;
   logic                          last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface htpm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [htpm_pkg::TOTAL_W-1:0] trigger_total;
   logic [htpm_pkg::INDEX_W-1:0] first_trigger;
   logic [htpm_pkg::INDEX_W-1:0] second_trigger;
   logic [htpm_pkg::INDEX_W-1:0] period_samples;
   logic                         period_valid;

   modport source (output valid, output trigger_total, output first_trigger,
                   output second_trigger, output period_samples, output period_valid,
                   input ready);
   modport sink   (input valid, input trigger_total, input first_trigger,
                   input second_trigger, input period_samples, input period_valid,
                   output ready);
endinterface

>>> hw/rtl/htpm_ctrl.sv
// Sequencing controller: sample run, end-of-capture divide, result handoff.
`timescale 1ns / 1ps

module htpm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  htpm_pkg::status_type status,
   output htpm_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_DIV = 2'd1;
   localparam logic [1:0] ST_OUT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       take;

   assign req_ready = (state_ff == ST_RUN);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in        = state_ff;
      cmd.accept      = take;
      cmd.capture_end = take && req_last;
      cmd.div_step    = 1'b0;
      cmd.load_out    = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (take && req_last) state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold here until the result register frees up
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/htpm_dp.sv
// Datapath: level registers, hysteresis compare, trigger record, serial divider.
`timescale 1ns / 1ps

module htpm_dp #(
   parameter int MAX_SAMPLES  = 4096,
   parameter int MAX_TRIGGERS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [htpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [htpm_pkg::LEVEL_W-1:0]        csr_wdata,
   input  logic [htpm_pkg::SAMPLE_W-1:0]       sample,
   input  htpm_pkg::cmd_type                   cmd,
   output htpm_pkg::status_type                status,
   output logic [htpm_pkg::TOTAL_W-1:0]        trigger_total,
   output logic [htpm_pkg::INDEX_W-1:0]        first_trigger,
   output logic [htpm_pkg::INDEX_W-1:0]        second_trigger,
   output logic [htpm_pkg::INDEX_W-1:0]        period_samples,
   output logic                                period_valid
);

   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_TRIGGERS + 1);
   localparam int STEP_W = $clog2(IDX_W);
   localparam int LVL_W  = htpm_pkg::LEVEL_W;
   localparam int SCL_W  = LVL_W + 3;
   localparam int TOT_W  = htpm_pkg::TOTAL_W;
   localparam int OIX_W  = htpm_pkg::INDEX_W;

   // level registers
   logic [LVL_W-1:0] max_ff, min_ff, mean_ff;

   // capture state
   logic             high_ff, high_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] first_ff, first_in;
   logic [IDX_W-1:0] second_ff, second_in;
   logic [IDX_W-1:0] latest_ff, latest_in;

   // end-of-capture operands and divider
   logic [CNT_W-1:0]  res_cnt_ff;
   logic [IDX_W-1:0]  res_first_ff, res_second_ff;
   logic              res_ok_ff;
   logic [IDX_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W:0]    trial;

   // result register
   logic [TOT_W-1:0] total_ff;
   logic [OIX_W-1:0] ofirst_ff, osecond_ff, period_ff;
   logic             pvalid_ff;

   // thresholds scaled by five
   logic [LVL_W:0]   lvl_sum;
   logic [LVL_W-1:0] centre;
   logic [SCL_W-1:0] lower5, upper5, s5;
   logic             start, rise, fall, record;

   assign lvl_sum = {1'b0, max_ff} + {1'b0, min_ff};
   assign centre  = lvl_sum[LVL_W:1];
   assign lower5  = SCL_W'({centre, 2'b00}) + SCL_W'(min_ff);
   assign upper5  = SCL_W'({centre, 2'b00}) + SCL_W'(max_ff);
   assign s5      = SCL_W'({sample, 2'b00}) + SCL_W'(sample);

   assign start  = (idx_ff == '0);
   assign fall   = !start && high_ff && (s5 < lower5);
   assign rise   = !start && !high_ff && (s5 > upper5);
   assign record = rise && (cnt_ff < CNT_W'(MAX_TRIGGERS));

   always_comb begin
      high_in   = high_ff;
      cnt_in    = cnt_ff;
      first_in  = first_ff;
      second_in = second_ff;
      latest_in = latest_ff;
      if (start) high_in = (sample > mean_ff);
      else if (fall) high_in = 1'b0;
      else if (rise) high_in = 1'b1;
      if (record) begin
         if (cnt_ff == CNT_W'(0)) first_in = idx_ff;
         else if (cnt_ff == CNT_W'(1)) second_in = idx_ff;
         latest_in = idx_ff;
         cnt_in    = cnt_ff + CNT_W'(1);
      end
      // index saturates at the last slot
      idx_in = (idx_ff == IDX_W'(MAX_SAMPLES - 1)) ? idx_ff : idx_ff + IDX_W'(1);
   end

   // restoring divide, one quotient bit a cycle
   assign trial = {rem_ff, quo_ff[IDX_W-1]};
   always_comb begin
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = CNT_W'(trial - {1'b0, dvs_ff});
         quo_in = {quo_ff[IDX_W-2:0], 1'b1};
      end else begin
         rem_in = trial[CNT_W-1:0];
         quo_in = {quo_ff[IDX_W-2:0], 1'b0};
      end
   end

   assign status.div_last = (step_ff == STEP_W'(IDX_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= htpm_pkg::MAX_LEVEL_RST;
         min_ff  <= htpm_pkg::MIN_LEVEL_RST;
         mean_ff <= htpm_pkg::MEAN_LEVEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            htpm_pkg::CSR_MAX_LEVEL:  max_ff  <= csr_wdata;
            htpm_pkg::CSR_MIN_LEVEL:  min_ff  <= csr_wdata;
            htpm_pkg::CSR_MEAN_LEVEL: mean_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.accept && cmd.capture_end)) begin
         high_ff   <= 1'b0;
         idx_ff    <= '0;
         cnt_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         latest_ff <= '0;
      end else if (cmd.accept) begin
         high_ff   <= high_in;
         idx_ff    <= idx_in;
         cnt_ff    <= cnt_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         latest_ff <= latest_in;
      end
   end

   // capture the final counts and seed the divider
   always_ff @(posedge clock) begin
      if (cmd.capture_end) begin
         res_cnt_ff    <= cnt_in;
         res_first_ff  <= first_in;
         res_second_ff <= second_in;
         res_ok_ff     <= (cnt_in >= CNT_W'(2));
         quo_ff        <= latest_in - first_in;
         rem_ff        <= '0;
         dvs_ff        <= cnt_in - CNT_W'(1);
         step_ff       <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (res_ok_ff) begin
            total_ff   <= TOT_W'(res_cnt_ff);
            ofirst_ff  <= OIX_W'(res_first_ff);
            osecond_ff <= OIX_W'(res_second_ff);
            period_ff  <= OIX_W'(quo_ff);
            pvalid_ff  <= 1'b1;
         end else begin
            total_ff   <= '0;
            ofirst_ff  <= '0;
            osecond_ff <= '0;
            period_ff  <= '0;
            pvalid_ff  <= 1'b0;
         end
      end
   end

   assign trigger_total  = total_ff;
   assign first_trigger  = ofirst_ff;
   assign second_trigger = osecond_ff;
   assign period_samples = period_ff;
   assign period_valid   = pvalid_ff;

endmodule

>>> hw/rtl/hysteresis_trigger_period_meter.sv
// Top level of the hysteresis trigger period meter.
`timescale 1ns / 1ps

// Usage:
// req_chan carries one ADC sample per beat; last marks the final sample of a
// capture. The first sample sets the starting side against mean_level; later
// samples are compared with a hysteresis band 20% of each half-range around
// the centre of max_level and min_level. Each rise through the upper edge
// after the signal was low records a trigger index, up to MAX_TRIGGERS.
// Samples inside a capture are taken one per cycle. After the beat with last,
// a shift-subtract divider forms (latest - first) / (count - 1) and req_chan
// drops ready until the result is loaded into the output register, which
// then raises one rsp_chan beat. While rsp_chan stalls, the next capture
// streams in, and only its end-of-capture handoff waits for the register to
// drain.
// csr_* writes max_level, min_level, mean_level (indexes 0, 1, 2).
// Reset restores the levels to 4095, 0, 2048, clears the capture and drops
// any pending result.

module hysteresis_trigger_period_meter #(
   parameter int MAX_SAMPLES  = 4096,
   parameter int MAX_TRIGGERS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   htpm_req_if.sink                          req_chan,
   htpm_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [htpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [htpm_pkg::LEVEL_W-1:0]      csr_wdata
);

   htpm_pkg::cmd_type    cmd;
   htpm_pkg::status_type status;

   htpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   htpm_dp #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .MAX_TRIGGERS (MAX_TRIGGERS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .sample         (req_chan.sample),
      .cmd            (cmd),
      .status         (status),
      .trigger_total  (rsp_chan.trigger_total),
      .first_trigger  (rsp_chan.first_trigger),
      .second_trigger (rsp_chan.second_trigger),
      .period_samples (rsp_chan.period_samples),
      .period_valid   (rsp_chan.period_valid)
   );

   // the end of a capture always closes the sample side for the divide
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last) |=> !req_chan.ready)
      else $error("sample beat taken right after end of capture");

   // a result without a period carries all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.period_valid) |->
      (rsp_chan.trigger_total == '0 && rsp_chan.first_trigger == '0 &&
       rsp_chan.second_trigger == '0 && rsp_chan.period_samples == '0))
      else $error("result without period has nonzero fields");

   // a new result only appears out of the divide, never during sampling
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> !$past(req_chan.ready))
      else $error("result raised while samples were being taken");

endmodule

>>> verif/tb_hysteresis_trigger_period_meter.sv
// Self-checking testbench: drives ADC captures and compares every period result.
`timescale 1ns / 1ps

module tb_hysteresis_trigger_period_meter;

   localparam int MAX_SAMPLES   = 4096;
   localparam int MAX_TRIGGERS  = 10;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SMP_W         = htpm_pkg::SAMPLE_W;
   localparam int LVL_W         = htpm_pkg::LEVEL_W;
   localparam int TOT_W         = htpm_pkg::TOTAL_W;
   localparam int IDX_W         = htpm_pkg::INDEX_W;
   localparam int CIX_W         = htpm_pkg::CSR_IDX_W;
   localparam int SAMPLE_TOP    = (1 << SMP_W) - 1;

   typedef enum {SHAPE_WAVE, SHAPE_EDGE, SHAPE_NOISE} wave_shape_type;

   typedef struct {
      logic [TOT_W-1:0] total;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] second;
      logic [IDX_W-1:0] period;
      logic             valid;
   } period_result_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CIX_W-1:0] csr_index;
   logic [LVL_W-1:0] csr_wdata;

   htpm_req_if req_chan ();
   htpm_rsp_if rsp_chan ();

   hysteresis_trigger_period_meter #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .MAX_TRIGGERS (MAX_TRIGGERS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Level registers as the block should hold them
   int level_max  = int'(htpm_pkg::MAX_LEVEL_RST);
   int level_min  = int'(htpm_pkg::MIN_LEVEL_RST);
   int level_mean = int'(htpm_pkg::MEAN_LEVEL_RST);

   // Capture state of the period meter model
   logic        side_high    = 1'b0;
   int unsigned sample_pos   = 0;
   int unsigned trig_count   = 0;
   int unsigned first_pos    = 0;
   int unsigned second_pos   = 0;
   int unsigned latest_pos   = 0;

   period_result_type expected_periods[$];
   int                mismatch_count = 0;
   int                beats_sent     = 0;
   int                req_idle_pct   = 0;
   int                rsp_idle_pct   = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advance the capture model by one sample; return 1 when a result is due.
   function automatic bit meter_sample(input logic [SMP_W-1:0] smp, input logic is_last,
                                       output period_result_type res);
      int          centre;
      int          smp5;
      int unsigned period;
      res = '{default: '0};
      if (sample_pos == 0) begin
         side_high = (int'(smp) > level_mean);
      end else begin
         centre = (level_max + level_min) / 2;
         smp5   = 5 * int'(smp);
         if (side_high && smp5 < 4 * centre + level_min) begin
            side_high = 1'b0;
         end else if (!side_high && smp5 > 4 * centre + level_max) begin
            if (trig_count < MAX_TRIGGERS) begin
               if (trig_count == 0)
                  first_pos = sample_pos;
               else if (trig_count == 1)
                  second_pos = sample_pos;
               latest_pos = sample_pos;
               trig_count++;
            end
            side_high = 1'b1;
         end
      end
      if (sample_pos < MAX_SAMPLES - 1)
         sample_pos++;
      if (!is_last)
         return 1'b0;
      if (trig_count >= 2) begin
         period     = (latest_pos - first_pos) / (trig_count - 1);
         res.total  = trig_count[TOT_W-1:0];
         res.first  = first_pos[IDX_W-1:0];
         res.second = second_pos[IDX_W-1:0];
         res.period = period[IDX_W-1:0];
         res.valid  = 1'b1;
      end
      side_high  = 1'b0;
      sample_pos = 0;
      trig_count = 0;
      first_pos  = 0;
      second_pos = 0;
      latest_pos = 0;
      return 1'b1;
   endfunction

   // Lowest sample that counts as above the band, highest that counts as below.
   function automatic void band_edges(output int rise_min, output int fall_max);
      int centre;
      centre   = (level_max + level_min) / 2;
      rise_min = (4 * centre + level_max) / 5 + 1;
      if (rise_min > SAMPLE_TOP)
         rise_min = SAMPLE_TOP;
      fall_max = (4 * centre + level_min - 1) / 5;
      if (fall_max < 0)
         fall_max = 0;
   endfunction

   task automatic compare_field(input string name, input int unsigned want, got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Check result beats first, then predict from the sample beat of the same edge.
   always @(posedge clock) begin
      period_result_type want;
      period_result_type next_res;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_periods.size() == 0) begin
               $error("result beat with no capture pending");
               mismatch_count++;
            end else begin
               want = expected_periods.pop_front();
               compare_field("trigger_total", 32'(want.total),
                             32'(rsp_chan.trigger_total));
               compare_field("first_trigger", 32'(want.first),
                             32'(rsp_chan.first_trigger));
               compare_field("second_trigger", 32'(want.second),
                             32'(rsp_chan.second_trigger));
               compare_field("period_samples", 32'(want.period),
                             32'(rsp_chan.period_samples));
               compare_field("period_valid", 32'(want.valid),
                             32'(rsp_chan.period_valid));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            if (meter_sample(req_chan.sample, req_chan.last, next_res))
               expected_periods.push_back(next_res);
         end
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_beat(input logic [SMP_W-1:0] smp, input logic is_last);
      if ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= smp;
      req_chan.last   <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      beats_sent++;
   endtask

   // Hold the sender until every pending result is back, then let the divider settle.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_periods.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_levels(input int max_v, min_v, mean_v);
      csr_we    <= 1'b1;
      csr_index <= htpm_pkg::CSR_MAX_LEVEL;
      csr_wdata <= max_v[LVL_W-1:0];
      @(posedge clock);
      csr_index <= htpm_pkg::CSR_MIN_LEVEL;
      csr_wdata <= min_v[LVL_W-1:0];
      @(posedge clock);
      csr_index <= htpm_pkg::CSR_MEAN_LEVEL;
      csr_wdata <= mean_v[LVL_W-1:0];
      @(posedge clock);
      csr_we     <= 1'b0;
      level_max  = max_v;
      level_min  = min_v;
      level_mean = mean_v;
   endtask

   task automatic send_capture(input int len, input wave_shape_type shape, input int half_max);
      int             rise_min;
      int             fall_max;
      int             run;
      logic           up;
      logic [SMP_W-1:0] smp;
      band_edges(rise_min, fall_max);
      up  = 1'($urandom_range(1));
      run = $urandom_range(half_max, 1);
      for (int i = 0; i < len; i++) begin
         case (shape)
            SHAPE_WAVE: begin
               if (run == 0) begin
                  up  = !up;
                  run = $urandom_range(half_max, 1);
               end
               run--;
               if ($urandom_range(9) == 0)
                  smp = SMP_W'($urandom_range(SAMPLE_TOP));
               else if (up)
                  smp = SMP_W'($urandom_range(SAMPLE_TOP, rise_min));
               else
                  smp = SMP_W'($urandom_range(fall_max, 0));
            end
            SHAPE_EDGE: begin
               case ($urandom_range(3))
                  0: smp = SMP_W'(rise_min);
                  1: smp = SMP_W'(rise_min - 1);
                  2: smp = SMP_W'(fall_max);
                  default: smp = SMP_W'(fall_max + 1);
               endcase
            end
            default: smp = SMP_W'($urandom_range(SAMPLE_TOP));
         endcase
         send_beat(smp, i == len - 1);
      end
   endtask

   task automatic test_single_sample();
      send_beat(SMP_W'(SAMPLE_TOP), 1'b1);
      send_beat(SMP_W'(0), 1'b1);
   endtask

   task automatic test_lone_trigger();
      send_beat(SMP_W'(0), 1'b0);
      send_beat(SMP_W'(SAMPLE_TOP), 1'b1);
   endtask

   // Eleven rising crossings: the last one sets the side but is not recorded.
   task automatic test_trigger_limit();
      send_beat(SMP_W'(0), 1'b0);
      repeat (MAX_TRIGGERS) begin
         send_beat(SMP_W'(SAMPLE_TOP), 1'b0);
         send_beat(SMP_W'(0), 1'b0);
      end
      send_beat(SMP_W'(SAMPLE_TOP), 1'b1);
   endtask

   // min above max turns the band inside out: one level is both above and below.
   task automatic test_inverted_band();
      drain_results();
      program_levels(100, 4000, 0);
      repeat (4) send_beat(SMP_W'(2000), 1'b0);
      send_beat(SMP_W'(2000), 1'b1);
   endtask

   // Run past the index range, with rising edges after the index has saturated.
   task automatic test_index_saturation();
      logic [SMP_W-1:0] smp;
      drain_results();
      program_levels(int'(htpm_pkg::MAX_LEVEL_RST), int'(htpm_pkg::MIN_LEVEL_RST),
                     int'(htpm_pkg::MEAN_LEVEL_RST));
      for (int i = 0; i < MAX_SAMPLES + 14; i++) begin
         if (i >= MAX_SAMPLES)
            smp = SMP_W'((i % 2 == 0) ? SAMPLE_TOP : 0);
         else
            smp = ((i / 700) % 2 == 1) ? SMP_W'($urandom_range(SAMPLE_TOP, 3000))
                                        : SMP_W'($urandom_range(1000, 0));
         send_beat(smp, i == MAX_SAMPLES + 13);
      end
   endtask

   task automatic pick_levels();
      int max_v;
      int min_v;
      case ($urandom_range(11))
         0: program_levels(SAMPLE_TOP, 0, 0);
         1: program_levels(SAMPLE_TOP, 0, SAMPLE_TOP);
         2: program_levels(0, 0, 0);
         3: program_levels(SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP);
         4: program_levels(0, SAMPLE_TOP, 2048);
         5: program_levels(int'(htpm_pkg::MAX_LEVEL_RST), int'(htpm_pkg::MIN_LEVEL_RST),
                           int'(htpm_pkg::MEAN_LEVEL_RST));
         6: program_levels($urandom_range(SAMPLE_TOP), $urandom_range(SAMPLE_TOP),
                           $urandom_range(SAMPLE_TOP));
         default: begin
            max_v = $urandom_range(SAMPLE_TOP, 200);
            min_v = $urandom_range(max_v - 100, 0);
            program_levels(max_v, min_v, $urandom_range(max_v, min_v));
         end
      endcase
   endtask

   task automatic test_random_captures(input int req_pct, rsp_pct, beat_count);
      int             stop_at;
      int             len;
      wave_shape_type shape;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      stop_at      = beats_sent + beat_count;
      while (beats_sent < stop_at) begin
         if ($urandom_range(3) == 0) begin
            drain_results();
            pick_levels();
         end
         case ($urandom_range(19))
            0, 1, 2: shape = SHAPE_EDGE;
            3, 4, 5: shape = SHAPE_NOISE;
            default: shape = SHAPE_WAVE;
         endcase
         len = ($urandom_range(6) == 0) ? $urandom_range(160, 25) : $urandom_range(24, 1);
         send_capture(len, shape, $urandom_range(8, 1));
      end
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = htpm_pkg::CSR_MAX_LEVEL;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      req_chan.last   = 1'b0;
      rsp_chan.ready  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 34;
      rsp_idle_pct = 58;
      test_single_sample();
      test_lone_trigger();
      test_trigger_limit();
      test_inverted_band();
      test_index_saturation();

      test_random_captures(34, 58, 440);
      test_random_captures(58, 34, 440);
      test_random_captures(0, 0, 440);

      drain_results();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
